// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL package
// Shared widths, lane indexes and the data carried along the divider chain.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int NUM_W  = 17;
  localparam int Q_W    = 9;
  localparam int DIV_W  = 9;
  localparam int REM_W  = 9;

  localparam int N_LANES    = 2;
  localparam int LANE_HUE   = 0;
  localparam int LANE_SAT   = 1;

  localparam int LMUL_W      = 14;
  localparam int LPROD_W     = NUM_W + LMUL_W;
  localparam int LIGHT_SHIFT = 20;

  localparam logic [NUM_W-1:0]  LIGHT_OFS = NUM_W'(51);
  localparam logic [LMUL_W-1:0] LIGHT_MUL = LMUL_W'(10281);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   nbits;
    logic [DIV_W-1:0] div;
    logic [Q_W-1:0]   quot;
  } lane_t;

  typedef struct packed {
    logic                     valid;
    logic [7:0]               alpha;
    logic [6:0]               light;
    lane_t [N_LANES-1:0]      lane;
  } cell_t;

endpackage

// ===== rtl/rhc_if.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL channel interfaces
// Valid/ready channels for the pixel request and the HSL result.
// ----------------------------------------------------------------------------
interface rhc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface rhc_hsl_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue_deg;
  logic [6:0] sat_pct;
  logic [6:0] light_pct;
  logic [7:0] alpha_out;
  modport source (output valid, hue_deg, sat_pct, light_pct, alpha_out, input ready);
  modport sink (input valid, hue_deg, sat_pct, light_pct, alpha_out, output ready);
endinterface

// ===== rtl/rgb_to_hsl_convert.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL converter
// The chain is one front stage and one divider cell per quotient bit.
// Throughput is one pixel per cycle while the chain is not held, since every stage then takes a new request each cycle.
// The whole chain holds while a finished result waits and out_hsl.ready is low.
// Synchronous active-low reset clears only the valid flags of the chain.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert
  import rhc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  rhc_pixel_if.sink    in_px,
  rhc_hsl_if.source    out_hsl
);

  logic  en;
  cell_t chain [Q_W+1];

  assign en = !(chain[Q_W].valid && !out_hsl.ready);
  assign in_px.ready = en;

  rhc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_px.valid),
    .red      (in_px.red),
    .green    (in_px.green),
    .blue     (in_px.blue),
    .alpha    (in_px.alpha),
    .cell_out (chain[0])
  );

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    rhc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  assign out_hsl.valid     = chain[Q_W].valid;
  assign out_hsl.hue_deg   = chain[Q_W].lane[LANE_HUE].quot;
  assign out_hsl.sat_pct   = chain[Q_W].lane[LANE_SAT].quot[6:0];
  assign out_hsl.light_pct = chain[Q_W].light;
  assign out_hsl.alpha_out = chain[Q_W].alpha;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> out_hsl.hue_deg < 9'd360)
    else $error("hue out of range");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> (out_hsl.sat_pct <= 7'd100 && out_hsl.light_pct <= 7'd100))
    else $error("percentage out of range");

  a_quot_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> (chain[Q_W].lane[LANE_SAT].quot[8:7] == 2'b00))
    else $error("quotient overflow");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsl.valid && !out_hsl.ready) |=> (out_hsl.valid && $stable(out_hsl.hue_deg)))
    else $error("result lost while stalled");

endmodule

// ===== rtl/rhc_prep.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL front stage
// Finds max and min, computes lightness and forms the hue and saturation ratios.
// ----------------------------------------------------------------------------
module rhc_prep
  import rhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] alpha,
  output cell_t      cell_out
);

  logic [7:0]        hi, lo, d, span, q;
  logic [8:0]        sum;
  logic signed [19:0] rs, gs, bs, ds, hnum;
  logic [NUM_W-1:0]  hue_num, sat_num, light_num;
  logic [LPROD_W-1:0] light_prod;
  logic [DIV_W-1:0]  hue_div, sat_div;
  cell_t             cell_nxt, cell_r;

  always_comb begin
    hi = red;
    lo = red;
    if (green > hi) hi = green;
    if (blue > hi) hi = blue;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
    sum  = 9'(hi) + 9'(lo);
    d    = hi - lo;
    span = (sum >= 9'd255) ? 8'(sum - 9'd255) : 8'(9'd255 - sum);
    q    = 8'd255 - span;
    rs   = 20'(red);
    gs   = 20'(green);
    bs   = 20'(blue);
    ds   = 20'(d);
    if (hi == red) begin
      if (green >= blue) hnum = 20'sd60 * (gs - bs);
      else hnum = 20'sd360 * ds - 20'sd60 * (bs - gs);
    end else if (hi == green) begin
      hnum = 20'sd120 * ds + 20'sd60 * (bs - rs);
    end else begin
      hnum = 20'sd240 * ds + 20'sd60 * (rs - gs);
    end
    light_num  = NUM_W'(sum) * NUM_W'(20) + LIGHT_OFS;
    light_prod = LPROD_W'(light_num) * LPROD_W'(LIGHT_MUL);
    if (d == 8'd0) begin
      hue_num = '0;
      hue_div = DIV_W'(1);
      sat_num = '0;
      sat_div = DIV_W'(1);
    end else begin
      hue_num = hnum[NUM_W-1:0];
      hue_div = DIV_W'(d);
      sat_num = NUM_W'(d) * NUM_W'(200) + NUM_W'(q);
      sat_div = {q, 1'b0};
    end
    cell_nxt.valid = in_valid;
    cell_nxt.alpha = alpha;
    cell_nxt.light = light_prod[LIGHT_SHIFT +: 7];
    cell_nxt.lane[LANE_HUE]   = '{rem: REM_W'(hue_num[NUM_W-1:Q_W]),
                                  nbits: hue_num[Q_W-1:0], div: hue_div, quot: '0};
    cell_nxt.lane[LANE_SAT]   = '{rem: REM_W'(sat_num[NUM_W-1:Q_W]),
                                  nbits: sat_num[Q_W-1:0], div: sat_div, quot: '0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.alpha <= cell_nxt.alpha;
      cell_r.light <= cell_nxt.light;
      cell_r.lane  <= cell_nxt.lane;
    end
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  assign cell_out = cell_r;

endmodule

// ===== rtl/rhc_div_cell.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL divider cell
// Produces one quotient bit for each of the two lanes and passes it on.
// ----------------------------------------------------------------------------
module rhc_div_cell
  import rhc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t cell_in,
  output cell_t cell_out
);

  logic [REM_W:0] trial [N_LANES];
  cell_t          cell_nxt, cell_r;

  always_comb begin
    cell_nxt = cell_in;
    for (int i = 0; i < N_LANES; i++) begin
      trial[i] = {cell_in.lane[i].rem, cell_in.lane[i].nbits[Q_W-1]};
      cell_nxt.lane[i].nbits = {cell_in.lane[i].nbits[Q_W-2:0], 1'b0};
      if (trial[i] >= {1'b0, cell_in.lane[i].div}) begin
        cell_nxt.lane[i].rem  = REM_W'(trial[i] - {1'b0, cell_in.lane[i].div});
        cell_nxt.lane[i].quot = {cell_in.lane[i].quot[Q_W-2:0], 1'b1};
      end else begin
        cell_nxt.lane[i].rem  = trial[i][REM_W-1:0];
        cell_nxt.lane[i].quot = {cell_in.lane[i].quot[Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r.alpha <= cell_nxt.alpha;
      cell_r.light <= cell_nxt.light;
      cell_r.lane  <= cell_nxt.lane;
    end
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  assign cell_out = cell_r;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Drives pixel requests with random gaps and result stalls, predicts each
// HSL result with exact integer arithmetic and checks results in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] light;
    logic [7:0] alpha;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t pending[$];
    int   mismatches;
    int   checked;

    function hsl_t convert(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [7:0] a);
      hsl_t res;
      int hi, lo, sum, d, span, q, num;
      hi = r; lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      sum = hi + lo;
      res.light = 7'((200 * sum + 510) / 1020);
      res.hue = '0;
      res.sat = '0;
      res.alpha = a;
      if (hi != lo) begin
        d = hi - lo;
        span = (sum >= 255) ? sum - 255 : 255 - sum;
        q = 255 - span;
        res.sat = 7'((200 * d + q) / (2 * q));
        if (hi == r) begin
          if (g >= b) num = 60 * (int'(g) - int'(b));
          else num = 360 * d - 60 * (int'(b) - int'(g));
        end else if (hi == g) begin
          num = 120 * d + 60 * (int'(b) - int'(r));
        end else begin
          num = 240 * d + 60 * (int'(r) - int'(g));
        end
        res.hue = 9'(num / d);
      end
      return res;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] a);
      pending.push_back(convert(r, g, b, a));
    endfunction

    function void check_result(hsl_t got);
      hsl_t exp;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: hue %0d sat %0d light %0d",
                                       got.hue, got.sat, got.light);
        return;
      end
      exp = pending.pop_front();
      if (exp != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected h%0d s%0d l%0d a%0d, got h%0d s%0d l%0d a%0d",
                   exp.hue, exp.sat, exp.light, exp.alpha,
                   got.hue, got.sat, got.light, got.alpha);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  rhc_pixel_if px_if();
  rhc_hsl_if   hsl_if();
  hsl_scoreboard sb;

  rgb_to_hsl_convert dut (
    .clk(clk), .rst_n(rst_n), .in_px(px_if.sink), .out_hsl(hsl_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, int gap);
    if (gap > 0) begin
      px_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    px_if.valid <= 1'b1;
    px_if.red   <= r;
    px_if.green <= g;
    px_if.blue  <= b;
    px_if.alpha <= a;
    do @(posedge clk); while (!px_if.ready);
    sb.note_pixel(r, g, b, a);
  endtask

  task automatic send_gap(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    send_pixel(r, g, b, a, gap);
  endtask

  initial begin
    int stall;
    hsl_t got;
    hsl_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        hsl_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hsl_if.ready <= 1'b1;
      do @(posedge clk); while (!hsl_if.valid);
      got.hue = hsl_if.hue_deg;
      got.sat = hsl_if.sat_pct;
      got.light = hsl_if.light_pct;
      got.alpha = hsl_if.alpha_out;
      sb.check_result(got);
    end
  end

  initial begin
    logic [7:0] r, g, b, v;
    sb = new();
    rst_n = 1'b0;
    px_if.valid = 1'b0;
    px_if.red = '0;
    px_if.green = '0;
    px_if.blue = '0;
    px_if.alpha = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd77, 0);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd1, 0);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd2, 0);
    send_pixel(8'd0, 8'd0, 8'd255, 8'd3, 0);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd4, 1);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd5, 0);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd6, 2);
    send_pixel(8'd255, 8'd0, 8'd1, 8'd7, 0);
    send_pixel(8'd255, 8'd1, 8'd0, 8'd8, 0);
    send_pixel(8'd1, 8'd0, 8'd0, 8'd9, 0);
    send_pixel(8'd255, 8'd254, 8'd254, 8'd10, 0);
    send_pixel(8'd200, 8'd100, 8'd200, 8'd170, 0);
    send_pixel(8'd10, 8'd200, 8'd200, 8'd85, 0);
    send_pixel(8'd1, 8'd2, 8'd3, 8'd240, 0);
    send_pixel(8'd127, 8'd128, 8'd0, 8'd15, 0);

    for (int i = 0; i < 950; i++) begin
      if (i == 400) begin
        px_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
      end
      v = 8'($urandom);
      case ($urandom_range(0, 5))
        0: begin r = v; g = v; b = v; end
        1: begin r = v; g = v; b = 8'($urandom); end
        2: begin r = 8'($urandom); g = v; b = v; end
        default: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
      endcase
      send_gap(r, g, b, 8'($urandom));
    end

    px_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (20) @(posedge clk);
    $display("Checked %0d HSL results over directed primaries, grays, ties and random pixels.",
             sb.checked);
    $display("Random gaps and output stalls of up to four cycles were applied.");
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
